/* sv/bf_pkg.sv */
// Shared types and constants of the 3x3 box filter.
package bf_pkg;

  localparam int PIX_W      = 8;
  localparam int ROW_W      = 12;
  localparam int OCOL_W     = 10;
  localparam int FW_W       = 11;
  localparam int SUM_W      = 12;
  localparam int CFG_DATA_W = 12;
  localparam int CFG_IDX_W  = 2;
  localparam int FIFO_DEPTH = 8;
  localparam int MIN_SIZE   = 3;
  localparam int RESET_SIZE = 512;
  // floor(x/9) == (x*3641) >> 15 for every x up to 9*255
  localparam int DIV9_MUL   = 3641;
  localparam int DIV9_SHIFT = 15;
  localparam int MUL_W      = SUM_W + 12;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH  = 2'd0,
    REG_FRAME_HEIGHT = 2'd1
  } cfg_reg_t;

  typedef struct packed {
    logic [ROW_W-1:0]  row;
    logic [OCOL_W-1:0] col;
    logic              emit;
    logic              last;
  } pos_t;

  typedef struct packed {
    logic [PIX_W-1:0]  mean;
    logic [ROW_W-1:0]  row;
    logic [OCOL_W-1:0] col;
    logic              last;
  } res_t;

endpackage

/* sv/bf_ifs.sv */
// Channel interfaces of the 3x3 box filter: pixel input, result output, configuration.
interface bf_pix_if;
  import bf_pkg::*;
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel_in;
  logic             frame_start;
  modport source (output valid, pixel_in, frame_start, input ready);
  modport sink (input valid, pixel_in, frame_start, output ready);
endinterface

interface bf_res_if;
  import bf_pkg::*;
  logic              valid;
  logic              ready;
  logic [PIX_W-1:0]  mean_pixel;
  logic [ROW_W-1:0]  out_row;
  logic [OCOL_W-1:0] out_col;
  logic              frame_last;
  modport source (output valid, mean_pixel, out_row, out_col, frame_last, input ready);
  modport sink (input valid, mean_pixel, out_row, out_col, frame_last, output ready);
endinterface

interface bf_cfg_if;
  import bf_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

/* sv/bf_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
module bf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* sv/bf_pos.sv */
// Configuration registers and raster position counters of the 3x3 box filter.
module bf_pos #(
  parameter int MAX_WIDTH = 1024,
  localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1
) (
  input  logic              clk,
  input  logic              rst,
  bf_cfg_if.sink            cfg,
  input  logic              accept,
  input  logic              frame_start,
  output logic [CW-1:0]     col,
  output bf_pkg::pos_t      pos
);
  import bf_pkg::*;

  localparam int WW      = $clog2(MAX_WIDTH + 1);
  localparam int RESET_W = (RESET_SIZE > MAX_WIDTH) ? MAX_WIDTH : RESET_SIZE;

  logic [WW-1:0]    eff_width;
  logic [ROW_W-1:0] eff_height;
  logic [CW-1:0]    column_count;
  logic [CW-1:0]    column_count_next;
  logic [ROW_W-1:0] row_count;
  logic [ROW_W-1:0] row_count_next;

  logic [FW_W-1:0]    fw;
  logic [ROW_W-1:0]   fh;
  logic [CW-1:0]      c_a;
  logic [CW-1:0]      c_cur;
  logic [ROW_W-1:0]   r_a;
  logic [ROW_W-1:0]   r_cur;
  logic [ROW_W:0]     r_b;
  logic [ROW_W:0]     r_inc;
  logic [CW:0]        c_inc;
  logic [CW+OCOL_W-1:0] c_m1;
  logic               wrap;
  logic               row_end;

  assign cfg.ready = 1'b1;
  assign fw = cfg.data[FW_W-1:0];
  assign fh = cfg.data[ROW_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      eff_width  <= WW'(RESET_W);
      eff_height <= ROW_W'(RESET_SIZE);
    end else if (cfg.valid) begin
      unique case (cfg_reg_t'(cfg.index))
        REG_FRAME_WIDTH: begin
          if (32'(fw) < 32'(MIN_SIZE)) begin
            eff_width <= WW'(MIN_SIZE);
          end else if (32'(fw) > 32'(MAX_WIDTH)) begin
            eff_width <= WW'(MAX_WIDTH);
          end else begin
            eff_width <= WW'(fw);
          end
        end
        REG_FRAME_HEIGHT: begin
          eff_height <= (32'(fh) < 32'(MIN_SIZE)) ? ROW_W'(MIN_SIZE) : fh;
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    c_a     = frame_start ? '0 : column_count;
    r_a     = frame_start ? '0 : row_count;
    wrap    = 32'(c_a) >= 32'(eff_width);
    c_cur   = wrap ? '0 : c_a;
    r_b     = {1'b0, r_a} + (ROW_W+1)'(wrap);
    r_cur   = (r_b >= {1'b0, eff_height}) ? '0 : r_b[ROW_W-1:0];
    c_inc   = {1'b0, c_cur} + (CW+1)'(1);
    row_end = 32'(c_inc) >= 32'(eff_width);
    r_inc   = {1'b0, r_cur} + (ROW_W+1)'(1);
    if (row_end) begin
      column_count_next = '0;
      row_count_next    = (r_inc >= {1'b0, eff_height}) ? '0 : r_inc[ROW_W-1:0];
    end else begin
      column_count_next = c_inc[CW-1:0];
      row_count_next    = r_cur;
    end
    c_m1     = (CW+OCOL_W)'(c_cur) - (CW+OCOL_W)'(1);
    col      = c_cur;
    pos.row  = r_cur - ROW_W'(1);
    pos.col  = c_m1[OCOL_W-1:0];
    pos.emit = (32'(c_cur) >= 32'd2) && (32'(r_cur) >= 32'd2);
    pos.last = (r_cur == eff_height - ROW_W'(1)) &&
               (32'(c_cur) == 32'(eff_width) - 32'd1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (accept) begin
      column_count <= column_count_next;
      row_count    <= row_count_next;
    end
  end

endmodule

/* sv/bf_win.sv */
// Line stores, 3x3 window registers and nine-pixel sum of the box filter.
module bf_win #(
  parameter int MAX_WIDTH = 1024,
  localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     accept,
  input  logic [CW-1:0]            in_col,
  input  logic [bf_pkg::PIX_W-1:0] in_pixel,
  input  bf_pkg::pos_t             in_pos,
  output logic                     sum_valid,
  output logic [bf_pkg::SUM_W-1:0] sum,
  output bf_pkg::pos_t             sum_pos
);
  import bf_pkg::*;

  logic             s1_valid;
  logic [CW-1:0]    s1_col;
  logic [PIX_W-1:0] s1_pixel;
  pos_t             s1_pos;
  logic             fwd;
  logic [PIX_W-1:0] fwd_top;
  logic [PIX_W-1:0] fwd_mid;
  logic [PIX_W-1:0] rd_a;
  logic [PIX_W-1:0] rd_b;
  logic [PIX_W-1:0] top;
  logic [PIX_W-1:0] mid;
  logic [PIX_W-1:0] win [6];
  logic [SUM_W-1:0] sum_next;

  bf_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_line_a (
    .clk   (clk),
    .we    (s1_valid),
    .waddr (s1_col),
    .wdata (s1_pixel),
    .raddr (in_col),
    .rdata (rd_a)
  );

  bf_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_line_b (
    .clk   (clk),
    .we    (s1_valid),
    .waddr (s1_col),
    .wdata (mid),
    .raddr (in_col),
    .rdata (rd_b)
  );

  always_comb begin
    top = fwd ? fwd_top : rd_b;
    mid = fwd ? fwd_mid : rd_a;
    sum_next = SUM_W'(top) + SUM_W'(mid) + SUM_W'(s1_pixel);
    for (int k = 0; k < 6; k++) begin
      sum_next = sum_next + SUM_W'(win[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      fwd       <= 1'b0;
      sum_valid <= 1'b0;
      for (int k = 0; k < 6; k++) begin
        win[k] <= '0;
      end
    end else begin
      s1_valid  <= accept;
      sum_valid <= s1_valid && s1_pos.emit;
      if (accept) begin
        fwd <= s1_valid && (s1_col == in_col);
      end
      if (s1_valid) begin
        win[0] <= win[3];
        win[1] <= win[4];
        win[2] <= win[5];
        win[3] <= top;
        win[4] <= mid;
        win[5] <= s1_pixel;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_col   <= in_col;
      s1_pixel <= in_pixel;
      s1_pos   <= in_pos;
      fwd_top  <= mid;
      fwd_mid  <= s1_pixel;
    end
    sum     <= sum_next;
    sum_pos <= s1_pos;
  end

endmodule

/* sv/bf_out.sv */
// Divide-by-nine stage, result queue and input credit of the box filter.
module bf_out (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     emit_accept,
  input  logic                     sum_valid,
  input  logic [bf_pkg::SUM_W-1:0] sum,
  input  bf_pkg::pos_t             sum_pos,
  output logic                     in_ready,
  bf_res_if.source                 res
);
  import bf_pkg::*;

  localparam int PW = $clog2(FIFO_DEPTH);
  localparam int NW = $clog2(FIFO_DEPTH + 1);

  logic [MUL_W-1:0] prod;
  logic             s3_valid;
  res_t             s3_res;
  res_t             fifo_mem [FIFO_DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [NW-1:0]    fill;
  logic [NW-1:0]    credit;
  logic             pop;
  res_t             head;

  assign prod     = MUL_W'(sum) * MUL_W'(DIV9_MUL);
  assign pop      = res.valid && res.ready;
  assign in_ready = credit < NW'(FIFO_DEPTH);
  assign head     = fifo_mem[rd_ptr];

  assign res.valid      = fill != '0;
  assign res.mean_pixel = head.mean;
  assign res.out_row    = head.row;
  assign res.out_col    = head.col;
  assign res.frame_last = head.last;

  always_ff @(posedge clk) begin
    s3_res.mean <= prod[DIV9_SHIFT +: PIX_W];
    s3_res.row  <= sum_pos.row;
    s3_res.col  <= sum_pos.col;
    s3_res.last <= sum_pos.last;
    if (s3_valid) begin
      fifo_mem[wr_ptr] <= s3_res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
      wr_ptr   <= '0;
      rd_ptr   <= '0;
      fill     <= '0;
      credit   <= '0;
    end else begin
      s3_valid <= sum_valid;
      if (s3_valid) begin
        wr_ptr <= PW'(wr_ptr + PW'(1));
      end
      if (pop) begin
        rd_ptr <= PW'(rd_ptr + PW'(1));
      end
      fill   <= fill + NW'(s3_valid) - NW'(pop);
      credit <= credit + NW'(emit_accept) - NW'(pop);
    end
  end

endmodule

/* sv/box_filter_3x3.sv */
// Top level of the streaming 3x3 box (mean) filter.
//
//  channel | dir | payload                                    | accepted when
//  pix     | in  | pixel_in, frame_start                      | pix.valid && pix.ready
//  res     | out | mean_pixel, out_row, out_col, frame_last   | res.valid && res.ready
//  cfg     | in  | index, data (0: frame_width, 1: frame_height) | cfg.valid && cfg.ready
//
// One pixel per cycle while pix.ready is high; results pass s1, sum, s3 and the queue.
// The line stores are read at the pixel's column on acceptance and written back in
// the cycle after; a same-column read in that cycle takes forwarded data.
// An eight-entry result queue with a credit count sets pix.ready; it drops only
// when eight results are pending. Reset clears counters, window and queue;
// the line stores hold unknown data until written. cfg.ready is always high.
module box_filter_3x3 #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic     clk,
  input  logic     rst,
  bf_pix_if.sink   pix,
  bf_res_if.source res,
  bf_cfg_if.sink   cfg
);
  import bf_pkg::*;

  localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

  logic             accept;
  logic             in_ready;
  logic [CW-1:0]    col;
  pos_t             pos;
  logic             sum_valid;
  logic [SUM_W-1:0] sum;
  pos_t             sum_pos;

  assign pix.ready = in_ready;
  assign accept    = pix.valid && in_ready;

  bf_pos #(.MAX_WIDTH(MAX_WIDTH)) u_pos (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .accept      (accept),
    .frame_start (pix.frame_start),
    .col         (col),
    .pos         (pos)
  );

  bf_win #(.MAX_WIDTH(MAX_WIDTH)) u_win (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .in_col    (col),
    .in_pixel  (pix.pixel_in),
    .in_pos    (pos),
    .sum_valid (sum_valid),
    .sum       (sum),
    .sum_pos   (sum_pos)
  );

  bf_out u_out (
    .clk         (clk),
    .rst         (rst),
    .emit_accept (accept && pos.emit),
    .sum_valid   (sum_valid),
    .sum         (sum),
    .sum_pos     (sum_pos),
    .in_ready    (in_ready),
    .res         (res)
  );

endmodule

/* sv/bf_chk.sv */
// Port-level assertions of the 3x3 box filter and their binding.
module bf_chk (
  input logic                     clk,
  input logic                     rst,
  input logic                     pix_valid,
  input logic                     pix_ready,
  input logic                     res_valid,
  input logic                     res_ready,
  input logic [bf_pkg::PIX_W-1:0] mean_pixel,
  input logic [bf_pkg::ROW_W-1:0] out_row
);
  import bf_pkg::*;

  a_reset_empties: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result valid after reset");

  a_row_interior: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> out_row != '0)
    else $error("result on border row");

  a_first_from_pixel: assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> $past(pix_valid && pix_ready, 4))
    else $error("result appeared without a pixel item four cycles before");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(mean_pixel))
    else $error("stalled result item changed");

endmodule

bind box_filter_3x3 bf_chk u_chk (
  .clk        (clk),
  .rst        (rst),
  .pix_valid  (pix.valid),
  .pix_ready  (pix.ready),
  .res_valid  (res.valid),
  .res_ready  (res.ready),
  .mean_pixel (res.mean_pixel),
  .out_row    (res.out_row)
);
